// ----- rtl/core/cfce_pkg.sv -----
// Package with the shared types, frame constants and CRC function of the framed command encoder.
`default_nettype none

package cfce_pkg;

    // Field widths of one request and one frame byte.
    localparam int unsigned TargetWidth  = 8;
    localparam int unsigned CommandWidth = 8;
    localparam int unsigned ValueWidth   = 16;
    localparam int unsigned ByteWidth    = 8;
    localparam int unsigned InDataWidth  = 40;
    localparam int unsigned IdxWidth     = 4;

    // Link framing bytes.
    localparam logic [ByteWidth-1:0] FRAME_DLE   = 8'd11;
    localparam logic [ByteWidth-1:0] FRAME_START = 8'd2;
    localparam logic [ByteWidth-1:0] FRAME_END   = 8'd3;
    localparam logic [ByteWidth-1:0] SIZE_SHORT  = 8'd4;
    localparam logic [ByteWidth-1:0] SIZE_LONG   = 8'd5;
    localparam logic [ByteWidth-1:0] CRC_POLY    = 8'h07;

    // Largest value that still goes out as a single byte.
    localparam logic [ValueWidth-1:0] SHORT_VALUE_MAX = 16'd255;

    // Byte positions inside a frame.
    localparam logic [IdxWidth-1:0] POS_DLE_HEAD = 4'd0;
    localparam logic [IdxWidth-1:0] POS_START    = 4'd1;
    localparam logic [IdxWidth-1:0] POS_SEQ      = 4'd2;
    localparam logic [IdxWidth-1:0] POS_SIZE     = 4'd3;
    localparam logic [IdxWidth-1:0] POS_COMMAND  = 4'd4;
    localparam logic [IdxWidth-1:0] POS_TARGET   = 4'd5;
    localparam logic [IdxWidth-1:0] POS_VALUE_LO = 4'd6;
    localparam logic [IdxWidth-1:0] POS_SEVEN    = 4'd7;
    localparam logic [IdxWidth-1:0] POS_EIGHT    = 4'd8;
    localparam logic [IdxWidth-1:0] POS_NINE     = 4'd9;
    localparam logic [IdxWidth-1:0] POS_TEN      = 4'd10;

    // One classified request as it waits for the serializer.
    typedef struct packed {
        logic                    long_value;
        logic                    sequence_bit;
        logic [ValueWidth-1:0]   value;
        logic [CommandWidth-1:0] command_code;
        logic [TargetWidth-1:0]  target_id;
    } desc_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    // One byte step of a CRC-8, MSB first, no reflection.
    function automatic logic [ByteWidth-1:0] crc8_update(
        input logic [ByteWidth-1:0] crc,
        input logic [ByteWidth-1:0] data
    );
        logic [ByteWidth-1:0] r;
        r = crc ^ data;
        for (int i = 0; i < ByteWidth; i++) begin
            if (r[ByteWidth-1]) begin
                r = {r[ByteWidth-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[ByteWidth-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfce_front.sv -----
// Front end: unpacks an incoming request item and classifies its value length.
`default_nettype none

module cfce_front (
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [cfce_pkg::InDataWidth-1:0]    s_tdata,
    input  wire cfce_pkg::queue_status_t             q_status,
    output logic                                     push,
    output cfce_pkg::desc_t                          push_desc
);

    // Take an item whenever the queue has room.
    assign s_tready = ~q_status.full;
    assign push     = s_tvalid & ~q_status.full;

    // Split tdata into fields and decide between the short and long frame.
    always_comb begin
        push_desc.target_id    = s_tdata[7:0];
        push_desc.command_code = s_tdata[15:8];
        push_desc.value        = s_tdata[31:16];
        push_desc.sequence_bit = s_tdata[32];
        push_desc.long_value   = (s_tdata[31:16] > cfce_pkg::SHORT_VALUE_MAX);
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfce_queue.sv -----
// Two-entry queue of classified requests between the front end and the serializer.
`default_nettype none

module cfce_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    push,
    input  wire cfce_pkg::desc_t         push_desc,
    input  wire logic                    pop,
    output cfce_pkg::desc_t              head_desc,
    output cfce_pkg::queue_status_t      status
);

    cfce_pkg::desc_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc        = mem_reg[rd_ptr_reg];
    assign status.full      = count_reg[1];
    assign status.not_empty = (count_reg != 2'd0);

endmodule

`default_nettype wire

// ----- rtl/core/cfce_back.sv -----
// Serializer: frames the head request with a running CRC, one byte per cycle unless stalled.
`default_nettype none

module cfce_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cfce_pkg::desc_t                   head_desc,
    input  wire cfce_pkg::queue_status_t           q_status,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [cfce_pkg::ByteWidth-1:0]         m_tdata,
    output logic                                   m_tlast
);

    logic [cfce_pkg::IdxWidth-1:0]  idx_reg, idx_next;
    logic [cfce_pkg::ByteWidth-1:0] crc_reg, crc_next;
    logic                           m_valid_reg, m_valid_next;
    logic [cfce_pkg::ByteWidth-1:0] m_data_reg;
    logic                           m_last_reg;

    logic [cfce_pkg::ByteWidth-1:0] cur_byte;
    logic                           cur_last;
    logic                           in_body;
    logic                           emit;

    // A new byte enters the output register when a request waits and it is empty or drains.
    assign emit = q_status.not_empty & (~m_valid_reg | m_tready);
    assign pop  = emit & cur_last;

    // Select the frame byte at the current position.
    always_comb begin
        cur_byte = cfce_pkg::FRAME_END;
        cur_last = 1'b0;
        in_body  = 1'b0;
        case (idx_reg)
            cfce_pkg::POS_DLE_HEAD: cur_byte = cfce_pkg::FRAME_DLE;
            cfce_pkg::POS_START:    cur_byte = cfce_pkg::FRAME_START;
            cfce_pkg::POS_SEQ: begin
                cur_byte = {{(cfce_pkg::ByteWidth-1){1'b0}}, head_desc.sequence_bit};
            end
            cfce_pkg::POS_SIZE: begin
                cur_byte = head_desc.long_value ? cfce_pkg::SIZE_LONG : cfce_pkg::SIZE_SHORT;
                in_body  = 1'b1;
            end
            cfce_pkg::POS_COMMAND: begin
                cur_byte = head_desc.command_code;
                in_body  = 1'b1;
            end
            cfce_pkg::POS_TARGET: begin
                cur_byte = head_desc.target_id;
                in_body  = 1'b1;
            end
            cfce_pkg::POS_VALUE_LO: begin
                cur_byte = head_desc.value[7:0];
                in_body  = 1'b1;
            end
            cfce_pkg::POS_SEVEN: begin
                cur_byte = head_desc.long_value ? head_desc.value[15:8] : crc_reg;
                in_body  = head_desc.long_value;
            end
            cfce_pkg::POS_EIGHT: begin
                cur_byte = head_desc.long_value ? crc_reg : cfce_pkg::FRAME_DLE;
            end
            cfce_pkg::POS_NINE: begin
                cur_byte = head_desc.long_value ? cfce_pkg::FRAME_DLE : cfce_pkg::FRAME_END;
                cur_last = ~head_desc.long_value;
            end
            cfce_pkg::POS_TEN: begin
                cur_byte = cfce_pkg::FRAME_END;
                cur_last = 1'b1;
            end
            default: begin
                cur_byte = cfce_pkg::FRAME_END;
                cur_last = 1'b1;
            end
        endcase
    end

    // Position counter advances with each emitted byte; the running CRC takes in body bytes.
    always_comb begin
        idx_next = idx_reg;
        crc_next = crc_reg;
        if (emit) begin
            if (cur_last) begin
                idx_next = cfce_pkg::POS_DLE_HEAD;
                crc_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (in_body) begin
                    crc_next = cfce_pkg::crc8_update(crc_reg, cur_byte);
                end
            end
        end
    end

    // Output valid follows new bytes and drains on acceptance.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= cfce_pkg::POS_DLE_HEAD;
            crc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= cur_byte;
            m_last_reg <= cur_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/crc8_framed_command_encoder.sv -----
// Top level of the CRC-8 framed command encoder.
// A taken request is written into the queue, then its first byte into the output register.
// Throughput: one frame byte per cycle unless m_tready stalls it; a frame is 10 bytes
// (value up to 255) or 11 bytes (larger value), as the byte serializer sends it.
// A two-entry request queue lets one more request be taken while the current frame is sent.
// Reset: synchronous, active low; it empties the queue and the output register.
`default_nettype none

module crc8_framed_command_encoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata from bit 0: target_id[7:0], command_code[15:8], value[31:16],
    // sequence_bit[32], zero padding[39:33]
    input  wire logic [cfce_pkg::InDataWidth-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata from bit 0: frame_byte[7:0]
    output logic [cfce_pkg::ByteWidth-1:0]         m_tdata,
    // m_tlast: last_byte
    output logic                                   m_tlast
);

    logic                    push;
    logic                    pop;
    cfce_pkg::desc_t         push_desc;
    cfce_pkg::desc_t         head_desc;
    cfce_pkg::queue_status_t q_status;

    // Request intake and classification.
    cfce_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    // Decoupling queue.
    cfce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    // Frame serializer.
    cfce_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_desc (head_desc),
        .q_status  (q_status),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/core/cfce_checker.sv -----
// Port-level checker of the framed command encoder and its bind to the top level.
`default_nettype none

module cfce_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [cfce_pkg::InDataWidth-1:0]  s_tdata,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [cfce_pkg::ByteWidth-1:0]    m_tdata,
    input wire logic                              m_tlast
);

    logic                           out_hs;
    logic [cfce_pkg::IdxWidth-1:0]  count_reg, count_next;
    logic [cfce_pkg::ByteWidth-1:0] prev_reg;

    assign out_hs = m_tvalid & m_tready;

    // Count bytes within the current frame.
    always_comb begin
        count_next = count_reg;
        if (out_hs) begin
            count_next = m_tlast ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Last byte taken from the output.
    always_ff @(posedge aclk) begin
        if (out_hs) begin
            prev_reg <= m_tdata;
        end
    end

    // A request item that waits keeps its data.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while waiting");

    // A stalled output byte holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed while stalled");

    // Every frame opens with DLE.
    a_frame_head: assert property (@(posedge aclk) disable iff (!aresetn)
        out_hs && count_reg == '0 |-> m_tdata == cfce_pkg::FRAME_DLE)
        else $error("frame does not start with DLE");

    // The closing byte is END right after DLE.
    a_frame_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        out_hs && m_tlast |-> m_tdata == cfce_pkg::FRAME_END
                              && prev_reg == cfce_pkg::FRAME_DLE)
        else $error("frame does not end with DLE END");

    // A frame is ten or eleven bytes long.
    a_frame_len: assert property (@(posedge aclk) disable iff (!aresetn)
        out_hs && m_tlast |-> count_reg == cfce_pkg::POS_NINE
                              || count_reg == cfce_pkg::POS_TEN)
        else $error("frame length is neither 10 nor 11 bytes");

endmodule

bind crc8_framed_command_encoder cfce_checker u_cfce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the CRC-8 framed command encoder.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned StallLimit   = 300;
    localparam int unsigned RandomItems  = 152;
    localparam int unsigned DrainCycles  = 20;
    localparam int unsigned DirectedRows = 18;

    // One directed request; gold selects the hand-written all-zero frame.
    typedef struct packed {
        logic                              gold;
        logic                              sequence_bit;
        logic [cfce_pkg::ValueWidth-1:0]   value;
        logic [cfce_pkg::CommandWidth-1:0] command_code;
        logic [cfce_pkg::TargetWidth-1:0]  target_id;
    } request_row_t;

    // One frame byte as it should leave the block.
    typedef struct packed {
        logic [cfce_pkg::ByteWidth-1:0] data;
        logic                           last;
    } frame_beat_t;

    // Frame of an all-zero request, worked out by hand; the sequence bit is patched in.
    localparam logic [cfce_pkg::ByteWidth-1:0] ZERO_FRAME [10] = '{
        cfce_pkg::FRAME_DLE, cfce_pkg::FRAME_START, 8'h00, cfce_pkg::SIZE_SHORT,
        8'h00, 8'h00, 8'h00, 8'h58, cfce_pkg::FRAME_DLE, cfce_pkg::FRAME_END
    };

    // Directed requests: extremes, the one/two-byte boundary, DLE-valued bytes.
    localparam request_row_t DIRECTED [DirectedRows] = '{
        '{1'b1, 1'b0, 16'h0000, 8'h00, 8'h00},
        '{1'b1, 1'b1, 16'h0000, 8'h00, 8'h00},
        '{1'b0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF},
        '{1'b0, 1'b0, 16'h00FF, 8'hFF, 8'hFF},
        '{1'b0, 1'b0, 16'h0100, 8'h00, 8'h00},
        '{1'b0, 1'b1, 16'h0001, 8'h04, 8'h12},
        '{1'b0, 1'b0, 16'h0064, 8'h05, 8'h34},
        '{1'b0, 1'b1, 16'h0168, 8'h06, 8'h56},
        '{1'b0, 1'b0, 16'h0B0B, 8'h0B, 8'h0B},
        '{1'b0, 1'b1, 16'h000B, 8'h0B, 8'h0B},
        '{1'b0, 1'b0, 16'h0302, 8'h02, 8'h03},
        '{1'b0, 1'b1, 16'hAA55, 8'h55, 8'hAA},
        '{1'b0, 1'b0, 16'h55AA, 8'hAA, 8'h55},
        '{1'b0, 1'b1, 16'h8000, 8'h80, 8'h01},
        '{1'b0, 1'b0, 16'h00FE, 8'h01, 8'h80},
        '{1'b0, 1'b1, 16'hFF00, 8'hFF, 8'h00},
        '{1'b0, 1'b0, 16'h0000, 8'h00, 8'hFF},
        '{1'b0, 1'b1, 16'h7FFF, 8'h7F, 8'h7F}
    };

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cfce_pkg::InDataWidth-1:0] s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cfce_pkg::ByteWidth-1:0]   m_tdata;
    logic                             m_tlast;

    frame_beat_t frame_bytes_due[$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    bit          calm        = 1'b0;

    crc8_framed_command_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // One step of CRC-8 with polynomial 0x07, fed one data bit at a time, MSB first.
    function automatic logic [cfce_pkg::ByteWidth-1:0] crc8_next(
        input logic [cfce_pkg::ByteWidth-1:0] crc,
        input logic [cfce_pkg::ByteWidth-1:0] data
    );
        logic [cfce_pkg::ByteWidth-1:0] c;
        c = crc;
        for (int i = cfce_pkg::ByteWidth - 1; i >= 0; i--) begin
            if (c[cfce_pkg::ByteWidth-1] ^ data[i]) begin
                c = {c[cfce_pkg::ByteWidth-2:0], 1'b0} ^ cfce_pkg::CRC_POLY;
            end else begin
                c = {c[cfce_pkg::ByteWidth-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic void push_beat(input logic [cfce_pkg::ByteWidth-1:0] data,
                                      input logic last);
        frame_beat_t beat;
        beat.data = data;
        beat.last = last;
        frame_bytes_due.push_back(beat);
    endfunction

    // Queue every byte of the frame that a request should produce.
    function automatic void queue_frame(
        input logic [cfce_pkg::TargetWidth-1:0]  target_id,
        input logic [cfce_pkg::CommandWidth-1:0] command_code,
        input logic [cfce_pkg::ValueWidth-1:0]   value,
        input logic                              sequence_bit
    );
        logic [cfce_pkg::ByteWidth-1:0] body [5];
        int                             body_len;
        logic [cfce_pkg::ByteWidth-1:0] crc;
        crc = '0;
        body[1] = command_code;
        body[2] = target_id;
        body[3] = value[7:0];
        body[4] = value[15:8];
        if (value > cfce_pkg::SHORT_VALUE_MAX) begin
            body[0]  = cfce_pkg::SIZE_LONG;
            body_len = 5;
        end else begin
            body[0]  = cfce_pkg::SIZE_SHORT;
            body_len = 4;
        end
        push_beat(cfce_pkg::FRAME_DLE, 1'b0);
        push_beat(cfce_pkg::FRAME_START, 1'b0);
        push_beat({7'd0, sequence_bit}, 1'b0);
        for (int k = 0; k < body_len; k++) begin
            push_beat(body[k], 1'b0);
            crc = crc8_next(crc, body[k]);
        end
        push_beat(crc, 1'b0);
        push_beat(cfce_pkg::FRAME_DLE, 1'b0);
        push_beat(cfce_pkg::FRAME_END, 1'b1);
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [cfce_pkg::ByteWidth-1:0] want,
                                   input logic [cfce_pkg::ByteWidth-1:0] got);
        $display("error at %0t: %s expected 0x%02h got 0x%02h", $realtime, what, want, got);
        error_count++;
    endtask

    // Offer a request after a random gap (none when calm); record its frame once taken.
    task automatic send_request(input request_row_t row, input logic [6:0] pad);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pad, row.sequence_bit, row.value, row.command_code, row.target_id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (row.gold) begin
            for (int k = 0; k < 10; k++) begin
                push_beat((k == 2) ? {7'd0, row.sequence_bit} : ZERO_FRAME[k], k == 9);
            end
        end else begin
            queue_frame(row.target_id, row.command_code, row.value, row.sequence_bit);
        end
    endtask

    // Hold the input side idle until every queued frame has gone out.
    task automatic drain_frames();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_bytes_due.size() != 0) @(posedge aclk);
    endtask

    // Stimulus: reset, directed table, then random requests.
    initial begin
        request_row_t row;
        int unsigned  sel;
        logic [6:0]   pad;
        logic         seq;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DirectedRows; i++) begin
            send_request(DIRECTED[i], 7'd0);
        end
        drain_frames();

        seq = 1'b0;
        for (int i = 0; i < RandomItems; i++) begin
            calm = (i >= 60 && i < 90) || (i >= 140);
            if (i == 100) begin
                drain_frames();
            end
            row.gold      = 1'b0;
            row.target_id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0) begin
                row.command_code = 8'(4 + $urandom_range(0, 2));
            end else begin
                row.command_code = 8'($urandom_range(0, 255));
            end
            sel = $urandom_range(0, 9);
            if (sel < 4) begin
                row.value = 16'($urandom_range(0, 255));
            end else if (sel < 8) begin
                row.value = 16'($urandom_range(256, 65535));
            end else begin
                case ($urandom_range(0, 3))
                    0: row.value = 16'h0000;
                    1: row.value = cfce_pkg::SHORT_VALUE_MAX;
                    2: row.value = cfce_pkg::SHORT_VALUE_MAX + 16'd1;
                    default: row.value = 16'hFFFF;
                endcase
            end
            // Mostly alternating, as a stop-and-wait sender would do.
            if ($urandom_range(0, 7) != 0) begin
                seq = ~seq;
            end
            row.sequence_bit = seq;
            // Padding bits above the fields must be ignored.
            pad = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) : 7'd0;
            send_request(row, pad);
        end

        drain_frames();
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Output side: random stalls unless calm; each taken byte is checked in order.
    initial begin
        int unsigned stall;
        frame_beat_t want;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("unexpected frame byte", 8'h00, m_tdata);
            end else begin
                want = frame_bytes_due.pop_front();
                if (m_tdata !== want.data) begin
                    report_mismatch("frame byte", want.data, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last byte flag", {7'd0, want.last}, {7'd0, m_tlast});
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    always @(posedge aclk) begin
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= StallLimit) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
